@@ sv/dad_pkg.sv @@
`default_nettype none

package dad_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ADD_W   = 15;
    // day count after adding: at most 366 + 32767
    localparam int DOY_W   = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_DEC   = 5'd31;

    // divisibility by 25: multiply by the inverse of 25 modulo 2^14,
    // the value is a multiple of 25 exactly when the product is small
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [DOY_W-1:0] a;
        logic [DOY_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DOY_W-1:0] res;
        logic             gt;
    } alu_rsp_t;

    // days in a month, february by leap flag
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                    input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return leap ? 16'd366 : 16'd365;
    endfunction

endpackage

`default_nettype wire

@@ sv/date_add_days_top.sv @@
// sequence: after the input transfer the walk waits for the leap flag, checks the day, sums the
//   earlier months and the days to add, steps over each year boundary crossed, then steps
//   the months of the final year; an out-of-range field gives its error result straight
//   from idle, a day beyond its month right after the day check
// throughput: one item at a time, the next is taken after the result transfer
// the walk runs on one shared add/subtract unit, and each year step waits for the registered leap check
// reset: synchronous active-low aresetn returns the sequencer to idle, no result pending
`default_nettype none

module date_add_days_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [dad_pkg::YEAR_W-1:0]  s_start_year,
    input  wire logic [dad_pkg::MONTH_W-1:0] s_start_month,
    input  wire logic [dad_pkg::DAY_W-1:0]   s_start_day,
    input  wire logic [dad_pkg::ADD_W-1:0]   s_days_to_add,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [dad_pkg::YEAR_W-1:0]       m_result_year,
    output logic [dad_pkg::MONTH_W-1:0]      m_result_month,
    output logic [dad_pkg::DAY_W-1:0]        m_result_day,
    output logic                             m_error_flag
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_VWAIT,
        S_DCHK,
        S_ACC,
        S_YWAIT,
        S_YSTEP,
        S_MSTEP,
        S_DONE
    } state_t;

    state_t                       state_reg;
    logic [dad_pkg::YEAR_W-1:0]   year_reg;
    logic [dad_pkg::MONTH_W-1:0]  month_reg;
    logic [dad_pkg::DAY_W-1:0]    day_reg;
    logic [dad_pkg::ADD_W-1:0]    add_reg;
    logic [dad_pkg::DOY_W-1:0]    doy_reg;
    logic [dad_pkg::MONTH_W-1:0]  m_reg;
    logic [dad_pkg::YEAR_W-1:0]   res_year_reg;
    logic [dad_pkg::MONTH_W-1:0]  res_month_reg;
    logic [dad_pkg::DAY_W-1:0]    res_day_reg;
    logic                         res_err_reg;

    logic                         leap;
    logic                         in_bad;
    logic [dad_pkg::DAY_W-1:0]    cur_mlen;
    dad_pkg::alu_req_t            alu_req;
    dad_pkg::alu_rsp_t            alu_rsp;

    dad_leap u_leap (
        .aclk     (aclk),
        .year     (year_reg),
        .leap_reg (leap)
    );

    dad_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // quick range checks on the incoming date
    assign in_bad = (s_start_year == '0) || (s_start_year > dad_pkg::YEAR_MAX) ||
                    (s_start_month == '0) || (s_start_month > dad_pkg::MONTH_DEC) ||
                    (s_start_day == '0);

    assign cur_mlen = dad_pkg::month_len(leap, m_reg);

    // operand select for the shared unit
    always_comb begin
        alu_req.op = dad_pkg::ALU_SUB;
        alu_req.a  = doy_reg;
        alu_req.b  = dad_pkg::DOY_W'(cur_mlen);
        unique case (state_reg)
            S_DCHK: begin
                alu_req.a = dad_pkg::DOY_W'(day_reg);
                alu_req.b = dad_pkg::DOY_W'(dad_pkg::month_len(leap, month_reg));
            end
            S_ACC: begin
                alu_req.op = dad_pkg::ALU_ADD;
                if (m_reg >= month_reg) begin
                    alu_req.b = dad_pkg::DOY_W'(add_reg);
                end
            end
            S_YSTEP: begin
                alu_req.b = dad_pkg::year_len(leap);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        year_reg  <= s_start_year;
                        month_reg <= s_start_month;
                        day_reg   <= s_start_day;
                        add_reg   <= s_days_to_add;
                        if (in_bad) begin
                            res_year_reg  <= '0;
                            res_month_reg <= '0;
                            res_day_reg   <= '0;
                            res_err_reg   <= 1'b1;
                            state_reg     <= S_DONE;
                        end else begin
                            state_reg <= S_VWAIT;
                        end
                    end
                end
                S_VWAIT: begin
                    state_reg <= S_DCHK;
                end
                S_DCHK: begin
                    // day beyond the month length
                    if (alu_rsp.gt) begin
                        res_year_reg  <= '0;
                        res_month_reg <= '0;
                        res_day_reg   <= '0;
                        res_err_reg   <= 1'b1;
                        state_reg     <= S_DONE;
                    end else begin
                        doy_reg   <= dad_pkg::DOY_W'(day_reg);
                        m_reg     <= 4'd1;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    // sum earlier months, then the days to add
                    doy_reg <= alu_rsp.res;
                    if (m_reg < month_reg) begin
                        m_reg <= m_reg + 4'd1;
                    end else begin
                        state_reg <= S_YSTEP;
                    end
                end
                S_YWAIT: begin
                    state_reg <= S_YSTEP;
                end
                S_YSTEP: begin
                    if (alu_rsp.gt) begin
                        if (year_reg >= dad_pkg::YEAR_MAX) begin
                            res_year_reg  <= dad_pkg::YEAR_MAX;
                            res_month_reg <= dad_pkg::MONTH_DEC;
                            res_day_reg   <= dad_pkg::DAY_DEC;
                            res_err_reg   <= 1'b1;
                            state_reg     <= S_DONE;
                        end else begin
                            doy_reg   <= alu_rsp.res;
                            year_reg  <= year_reg + 14'd1;
                            state_reg <= S_YWAIT;
                        end
                    end else begin
                        m_reg     <= 4'd1;
                        state_reg <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    if ((m_reg < dad_pkg::MONTH_DEC) && alu_rsp.gt) begin
                        doy_reg <= alu_rsp.res;
                        m_reg   <= m_reg + 4'd1;
                    end else begin
                        res_year_reg  <= year_reg;
                        res_month_reg <= m_reg;
                        res_day_reg   <= doy_reg[dad_pkg::DAY_W-1:0];
                        res_err_reg   <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_DONE);
    assign m_result_year  = res_year_reg;
    assign m_result_month = res_month_reg;
    assign m_result_day   = res_day_reg;
    assign m_error_flag   = res_err_reg;

endmodule

`default_nettype wire

@@ sv/dad_leap.sv @@
`default_nettype none

module dad_leap (
    input  wire logic                       aclk,
    input  wire logic [dad_pkg::YEAR_W-1:0] year,
    output logic                            leap_reg
);

    logic [dad_pkg::YEAR_W-1:0] prod_lo;
    logic                       div25;
    logic                       div4;
    logic                       div16;
    logic                       leap_next;

    // multiple of 25 test through the modular inverse
    assign prod_lo = year * dad_pkg::INV25;
    assign div25   = (prod_lo <= dad_pkg::DIV25_LIM);
    assign div4    = (year[1:0] == 2'd0);
    assign div16   = (year[3:0] == 4'd0);

    // div by 4 and not by 100, or div by 400
    assign leap_next = (div4 && !div25) || (div16 && div25);

    always_ff @(posedge aclk) begin
        leap_reg <= leap_next;
    end

endmodule

`default_nettype wire

@@ sv/dad_alu.sv @@
`default_nettype none

module dad_alu (
    input  wire dad_pkg::alu_req_t req,
    output dad_pkg::alu_rsp_t      rsp
);

    // shared add/subtract with magnitude compare
    always_comb begin
        rsp.res = (req.op == dad_pkg::ALU_ADD) ? (req.a + req.b) : (req.a - req.b);
        rsp.gt  = (req.a > req.b);
    end

endmodule

`default_nettype wire

@@ sv/dad_checker.sv @@
`default_nettype none

module dad_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [dad_pkg::YEAR_W-1:0]  m_result_year,
    input wire logic [dad_pkg::MONTH_W-1:0] m_result_month,
    input wire logic [dad_pkg::DAY_W-1:0]   m_result_day,
    input wire logic                        m_error_flag
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_year) &&
            $stable(m_result_month) && $stable(m_result_day) && $stable(m_error_flag))
        else $error("result changed while stalled");

    // one item in flight: never ready while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // busy after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after input transfer");

    // a good result has a nonzero day and a year and month in range
    a_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error_flag |-> (m_result_year != '0) &&
            (m_result_year <= dad_pkg::YEAR_MAX) && (m_result_month != '0) &&
            (m_result_month <= dad_pkg::MONTH_DEC) && (m_result_day != '0))
        else $error("result date out of range");

    // an error result is either all zero or the saturated last day
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag && (m_result_year != '0) |->
            (m_result_year == dad_pkg::YEAR_MAX) && (m_result_month == dad_pkg::MONTH_DEC) &&
            (m_result_day == dad_pkg::DAY_DEC))
        else $error("bad saturated result");

endmodule

bind date_add_days_top dad_checker u_dad_checker (.*);

`default_nettype wire
